// ===== rtl/core/bda_pkg.sv =====
// Shared constants for the binary to decimal ASCII converter.
package bda_pkg;
	localparam int VALUE_WIDTH = 64;
	localparam int IN_WIDTH    = 64;
	localparam int CHAR_WIDTH  = 6;
	localparam int MAX_DIGITS  = 20;
	localparam int BCD_WIDTH   = MAX_DIGITS * 4;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_W       = $clog2(MAX_DIGITS);
	localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);

	typedef logic [IN_WIDTH-1:0]   value_t;
	typedef logic [CHAR_WIDTH-1:0] char_t;
endpackage

// ===== rtl/core/bda_in_if.sv =====
// Input channel: one binary value per transaction.
interface bda_in_if;
	import bda_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/core/bda_out_if.sv =====
// Output channel: one ASCII digit per transaction with an end-of-run mark.
interface bda_out_if;
	import bda_pkg::*;

	logic  valid;
	logic  ready;
	char_t digit_char;
	logic  is_last;

	modport source (output valid, output digit_char, output is_last, input ready);
	modport sink (input valid, input digit_char, input is_last, output ready);
endinterface

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
// Bit-serial double dabble converter from binary to decimal ASCII digits.
//
//   channel | direction | payload
//   din     | in        | value[63:0]
//   dout    | out       | digit_char[5:0], is_last
//
// A value is first shifted bit by bit through the BCD register, then the 20
// digit positions are scanned at one position per cycle, a digit waiting while
// the output stage is full; leading zero positions are skipped. A new value is
// taken once the last digit sits in the output register. The output stage holds
// while dout.ready is low. Reset clears the state and the output valid.
module binary_to_decimal_ascii_unit (
	input logic       clk,
	input logic       arst_n,
	bda_in_if.sink    din,
	bda_out_if.source dout
);
	import bda_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_WIDTH-1:0]   bcd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIG_W-1:0]       dig_q;
	logic                   started_q;
	logic                   out_valid_q;
	char_t                  out_char_q;
	logic                   out_last_q;

	logic [BCD_WIDTH-1:0]   bcd_adj;
	logic [3:0]             top_digit;
	logic                   last_pos;
	logic                   slot_free;
	logic                   skip_lead;
	logic                   emit_go;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_WIDTH-1 -: 4];
	assign last_pos  = (dig_q == DIG_W'(MAX_DIGITS - 1));
	assign slot_free = !out_valid_q || dout.ready;
	assign skip_lead = !started_q && (top_digit == 4'd0) && !last_pos;
	assign emit_go   = (state_q == ST_EMIT) && !skip_lead && slot_free;

	assign din.ready       = (state_q == ST_IDLE);
	assign dout.valid      = out_valid_q;
	assign dout.digit_char = out_char_q;
	assign dout.is_last    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			cnt_q       <= '0;
			dig_q       <= '0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						bin_q     <= din.value[VALUE_WIDTH-1:0];
						bcd_q     <= '0;
						cnt_q     <= CNT_W'(VALUE_WIDTH);
						dig_q     <= '0;
						started_q <= 1'b0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q <= {bcd_adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
					bin_q <= bin_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (skip_lead) begin
						bcd_q <= bcd_q << 4;
						dig_q <= dig_q + 1'b1;
					end else if (slot_free) begin
						out_char_q <= ASCII_ZERO + char_t'(top_digit);
						out_last_q <= last_pos;
						started_q  <= 1'b1;
						bcd_q      <= bcd_q << 4;
						dig_q      <= dig_q + 1'b1;
						if (last_pos) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
